// ----- rtl/rgb_to_hsl_converter_core_assert.svh -----
// Assertion macros shared by the checker of the RGB to HSL converter.
// Each macro expands to one labeled concurrent assertion on the given clock; RHC_ASSERT also takes a reset.
`ifndef RGB_TO_HSL_CONVERTER_CORE_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_CORE_ASSERT_SVH

// Property that must hold at every edge outside reset.
`define RHC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: label failed");

// Property that must hold at every edge, including during reset.
`define RHC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("%m: label failed");

`endif

// ----- rtl/rhc_pkg.sv -----
// Package of the RGB to HSL converter: field widths, lane indexes and constants.
// Used by every module of the block; depends on nothing.
package rhc_pkg;
   localparam int CH_W     = 8;
   localparam int HUE_W    = 15;
   localparam int PCT_W    = 13;
   localparam int LANES    = 3;
   localparam int DEN_W    = 10;
   localparam int REQ_W    = 24;
   localparam int RSP_W    = 48;
   localparam int LANE_HUE = 0;
   localparam int LANE_LIG = 1;
   localparam int LANE_SAT = 2;
endpackage

// ----- rtl/rhc_prep.sv -----
// Front stage: max, min, delta and the rounded numerators and divisors of three divisions.
// Depends on rhc_pkg.
module rhc_prep #(
   parameter int FRAC_BITS = 6,
   parameter int NW        = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [rhc_pkg::CH_W-1:0]  red,
   input  logic [rhc_pkg::CH_W-1:0]  green,
   input  logic [rhc_pkg::CH_W-1:0]  blue,
   output logic                      out_valid,
   output logic [NW-1:0]             out_rem [rhc_pkg::LANES],
   output logic [rhc_pkg::DEN_W-1:0] out_den [rhc_pkg::LANES]
);
   import rhc_pkg::*;

   logic [CH_W-1:0]  mx, mn, dl;
   logic [CH_W:0]    sum, sden;
   logic [10:0]      span;
   logic             valid_ff;
   logic [NW-1:0]    rem_ff [LANES];
   logic [NW-1:0]    rem_in [LANES];
   logic [DEN_W-1:0] den_ff [LANES];
   logic [DEN_W-1:0] den_in [LANES];

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      dl = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      sden = (sum <= 9'd255) ? sum : (9'd510 - sum);
      if (mx == red) begin
         span = (green >= blue) ? 11'(green - blue)
                                : (11'(dl) * 11'd6 - 11'(blue - green));
      end else if (mx == green) begin
         span = (blue >= red) ? (11'(dl) * 11'd2 + 11'(blue - red))
                              : (11'(dl) * 11'd2 - 11'(red - blue));
      end else begin
         span = (red >= green) ? (11'(dl) * 11'd4 + 11'(red - green))
                               : (11'(dl) * 11'd4 - 11'(green - red));
      end
      rem_in[LANE_LIG] = ((NW'(sum) * NW'(200)) << FRAC_BITS) + NW'(510);
      den_in[LANE_LIG] = DEN_W'(1020);
      if (dl == '0) begin
         rem_in[LANE_HUE] = '0;
         den_in[LANE_HUE] = DEN_W'(2);
         rem_in[LANE_SAT] = '0;
         den_in[LANE_SAT] = DEN_W'(2);
      end else begin
         rem_in[LANE_HUE] = ((NW'(span) * NW'(120)) << FRAC_BITS) + NW'(dl);
         den_in[LANE_HUE] = DEN_W'({dl, 1'b0});
         rem_in[LANE_SAT] = ((NW'(dl) * NW'(200)) << FRAC_BITS) + NW'(sden);
         den_in[LANE_SAT] = DEN_W'({sden, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
endmodule

// ----- rtl/rhc_div_cell.sv -----
// One restoring division cell: settles one quotient bit in each of the three lanes.
// Depends on rhc_pkg.
module rhc_div_cell #(
   parameter int NW  = 25,
   parameter int QW  = 15,
   parameter int BIT = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [NW-1:0]             in_rem [rhc_pkg::LANES],
   input  logic [rhc_pkg::DEN_W-1:0] in_den [rhc_pkg::LANES],
   input  logic [QW-1:0]             in_quo [rhc_pkg::LANES],
   output logic                      out_valid,
   output logic [NW-1:0]             out_rem [rhc_pkg::LANES],
   output logic [rhc_pkg::DEN_W-1:0] out_den [rhc_pkg::LANES],
   output logic [QW-1:0]             out_quo [rhc_pkg::LANES]
);
   import rhc_pkg::*;

   logic             valid_ff;
   logic [NW-1:0]    trial  [LANES];
   logic [NW-1:0]    rem_in [LANES];
   logic [NW-1:0]    rem_ff [LANES];
   logic [QW-1:0]    quo_in [LANES];
   logic [QW-1:0]    quo_ff [LANES];
   logic [DEN_W-1:0] den_ff [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         trial[l] = NW'(in_den[l]) << BIT;
         if (in_rem[l] >= trial[l]) begin
            rem_in[l] = in_rem[l] - trial[l];
            quo_in[l] = {in_quo[l][QW-2:0], 1'b1};
         end else begin
            rem_in[l] = in_rem[l];
            quo_in[l] = {in_quo[l][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         den_ff <= in_den;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
endmodule

// ----- rtl/rgb_to_hsl_converter_core.sv -----
// RGB to HSL converter: one prep stage, a chain of FRAC_BITS+9 division cells, one output register.
// One request is taken every cycle unless the result is stalled.
// The depth is set by the division cell chain, one quotient bit per cell for all three outputs.
// A stalled result holds the whole pipeline. Reset clears all valid bits; the block is ready at once.
// Depends on rhc_pkg, rhc_prep and rhc_div_cell.
module rgb_to_hsl_converter_core #(
   parameter int FRAC_BITS = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [rhc_pkg::REQ_W-1:0] req_tdata,  // red, green, blue
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [rhc_pkg::RSP_W-1:0] rsp_tdata   // hue_angle, lightness_pct, saturation_pct, zeros
);
   import rhc_pkg::*;

   localparam int QW = FRAC_BITS + 9;
   localparam int NW = FRAC_BITS + 19;

   logic             en;
   logic             vld_w [QW+1];
   logic [NW-1:0]    rem_w [QW+1][LANES];
   logic [DEN_W-1:0] den_w [QW+1][LANES];
   logic [QW-1:0]    quo_w [QW+1][LANES];
   logic [QW-1:0]    hue_q;
   logic [QW+HUE_W-1:0] hue_x;
   logic [QW+PCT_W-1:0] lig_x, sat_x;
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] rsp_data_in;

   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   rhc_prep #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (vld_w[0]),
      .out_rem   (rem_w[0]),
      .out_den   (den_w[0])
   );

   always_comb begin
      for (int l = 0; l < LANES; l++) quo_w[0][l] = '0;
   end

   for (genvar k = 0; k < QW; k++) begin : g_cell
      rhc_div_cell #(.NW(NW), .QW(QW), .BIT(QW-1-k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (vld_w[k]),
         .in_rem    (rem_w[k]),
         .in_den    (den_w[k]),
         .in_quo    (quo_w[k]),
         .out_valid (vld_w[k+1]),
         .out_rem   (rem_w[k+1]),
         .out_den   (den_w[k+1]),
         .out_quo   (quo_w[k+1])
      );
   end

   always_comb begin
      hue_q = quo_w[QW][LANE_HUE];
      if (hue_q >= (QW'(360) << FRAC_BITS)) hue_q = hue_q - (QW'(360) << FRAC_BITS);
      hue_x = {{HUE_W{1'b0}}, hue_q};
      lig_x = {{PCT_W{1'b0}}, quo_w[QW][LANE_LIG]};
      sat_x = {{PCT_W{1'b0}}, quo_w[QW][LANE_SAT]};
      rsp_data_in = {7'd0, sat_x[PCT_W-1:0], lig_x[PCT_W-1:0], hue_x[HUE_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_w[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

// ----- rtl/rhc_checker.sv -----
// Port checker for the RGB to HSL converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsl_converter_core_assert.svh.
`include "rgb_to_hsl_converter_core_assert.svh"

module rhc_checker #(
   parameter int FRAC_BITS = 6
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [rhc_pkg::REQ_W-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [rhc_pkg::RSP_W-1:0] rsp_tdata
);
   import rhc_pkg::*;

   `RHC_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_tvalid)
   `RHC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `RHC_ASSERT(a_ready_when_free, clock, reset, !rsp_tvalid || rsp_tready |-> req_tready)
   `RHC_ASSERT(a_range, clock, reset, rsp_tvalid && FRAC_BITS == 6 |-> rsp_tdata[14:0] < 15'd23040 && rsp_tdata[27:15] <= 13'd6400 && rsp_tdata[40:28] <= 13'd6400)
endmodule

bind rgb_to_hsl_converter_core rhc_checker #(.FRAC_BITS(FRAC_BITS)) u_rhc_checker (.*);
